// ===== rtl/jrd_pkg.sv =====
// ----------------------------------------------------------------------------
// jrd_pkg: shared types and constants of the joystick report deframer
// Holds the packet layout constants, register addresses and the result type.
// ----------------------------------------------------------------------------
package jrd_pkg;

    localparam int NUM_STICKS      = 2;
    localparam int BYTES_PER_STICK = 8;
    localparam int PHASE_W         = 5;
    localparam int AXIS_W          = 12;
    localparam int PADDR_W         = 3;

    // Register word indexes (byte address bits [2:2])
    localparam logic REG_CONNECTED_MASK = 1'b0;

    // Packet positions
    localparam logic [PHASE_W-1:0] PH_STATUS    = 5'd0;
    localparam logic [PHASE_W-1:0] PH_MODE      = 5'd1;
    localparam logic [PHASE_W-1:0] PH_DATA_BASE = 5'd2;

    // Status byte bits
    localparam int ST_PRESENT0 = 6;
    localparam int ST_PRESENT1 = 7;
    localparam int ST_ERROR0   = 5;
    localparam int ST_ERROR1   = 4;

    // Data byte slots within one stick's block
    localparam int SLOT_X_HI   = 0;
    localparam int SLOT_Y_HI   = 1;
    localparam int SLOT_Z_HI   = 2;
    localparam int SLOT_T_HI   = 3;
    localparam int SLOT_XY_LO  = 4;
    localparam int SLOT_ZT_LO  = 5;
    localparam int SLOT_BUTTON = 6;
    localparam int SLOT_HAT    = 7;

    typedef logic [BYTES_PER_STICK-1:0][7:0] stick_bytes_t;

    typedef struct packed {
        logic              joy_index;
        logic              present;
        logic [AXIS_W-1:0] axis_x;
        logic [AXIS_W-1:0] axis_y;
        logic [AXIS_W-1:0] axis_z;
        logic [AXIS_W-1:0] axis_throttle;
        logic [3:0]        buttons;
        logic [7:0]        hat_raw;
        logic              data_error;
        logic              checksum_ok;
        logic              last;
    } result_t;

endpackage

// ===== rtl/joystick_report_deframer_top.sv =====
// ----------------------------------------------------------------------------
// joystick_report_deframer_top: two-joystick report packet deframer
// Collects the bytes of one report packet and, on its checksum byte, issues
// one result beat per joystick with the unpacked axes, buttons and flags.
// ----------------------------------------------------------------------------
// Output: the first result beat is valid in the cycle after the checksum byte
// is accepted, the second follows as soon as the first is taken.
// Throughput: one byte per cycle; a checksum byte is held off only while a
// result beat of the previous packet is still waiting at the output.
// Reset: rst_n clears the packet position, the running sum, the status byte,
// the connected mask and the output buffer; the next byte is taken as status.
module joystick_report_deframer_top (
    input  logic                          clk,
    input  logic                          rst_n,
    // APB-style configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [jrd_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    // Byte input
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [7:0]                    rx_byte,
    // Result output
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          joy_index,
    output logic                          present,
    output logic [jrd_pkg::AXIS_W-1:0]    axis_x,
    output logic [jrd_pkg::AXIS_W-1:0]    axis_y,
    output logic [jrd_pkg::AXIS_W-1:0]    axis_z,
    output logic [jrd_pkg::AXIS_W-1:0]    axis_throttle,
    output logic [3:0]                    buttons,
    output logic [7:0]                    hat_raw,
    output logic                          data_error,
    output logic                          checksum_ok,
    output logic                          last
);
    import jrd_pkg::*;

    logic [1:0]         connected_reg;
    logic [PHASE_W-1:0] phase_reg;
    logic [PHASE_W-1:0] phase_next;
    logic [7:0]         status_reg;
    logic [7:0]         sum_reg;
    logic [7:0]         sum_next;
    stick_bytes_t       joy_bytes_reg [NUM_STICKS];

    result_t            res0_reg;
    result_t            res1_reg;
    result_t            res0_next;
    result_t            res1_next;
    result_t            res_out;
    logic               pend0_reg;
    logic               pend1_reg;

    logic               cfg_write;
    logic [PHASE_W-1:0] data_len;
    logic [PHASE_W-1:0] data_off;
    logic               is_cksum;
    logic               in_fire;
    logic               out_fire;
    logic               wr_stick;
    logic [2:0]         wr_slot;
    logic               sum_ok;

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_CONNECTED_MASK)
        begin
            prdata = {30'd0, connected_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            connected_reg <= 2'b00;
        end
        else if (cfg_write && (paddr[2] == REG_CONNECTED_MASK))
        begin
            connected_reg <= pwdata[1:0];
        end
    end

    // ------------------------------------------------------------------
    // Packet position decode
    // ------------------------------------------------------------------
    assign data_len = {status_reg[ST_PRESENT0] & status_reg[ST_PRESENT1],
                       status_reg[ST_PRESENT0] ^ status_reg[ST_PRESENT1],
                       3'b000};
    assign data_off = phase_reg - PH_DATA_BASE;
    assign is_cksum = (phase_reg != PH_STATUS) && (phase_reg != PH_MODE) &&
                      (data_off == data_len);

    // Data for joystick 1 alone lands in its own block from the first byte.
    assign wr_stick = data_off[3] | ~status_reg[ST_PRESENT0];
    assign wr_slot  = data_off[2:0];

    assign in_stall = is_cksum && (pend0_reg || pend1_reg);
    assign in_fire  = in_valid && !in_stall;
    assign sum_ok   = (sum_reg == rx_byte);

    always_comb
    begin
        phase_next = phase_reg;
        sum_next   = sum_reg;
        priority if (phase_reg == PH_STATUS)
        begin
            phase_next = PH_MODE;
            sum_next   = rx_byte;
        end
        else if (is_cksum)
        begin
            phase_next = PH_STATUS;
            sum_next   = 8'd0;
        end
        else
        begin
            phase_next = phase_reg + PHASE_W'(1);
            sum_next   = sum_reg + rx_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_STATUS;
            sum_reg    <= 8'd0;
            status_reg <= 8'd0;
        end
        else if (in_fire)
        begin
            phase_reg <= phase_next;
            sum_reg   <= sum_next;
            if (phase_reg == PH_STATUS)
            begin
                status_reg <= rx_byte;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && (phase_reg != PH_STATUS) && (phase_reg != PH_MODE) && !is_cksum)
        begin
            joy_bytes_reg[wr_stick][wr_slot] <= rx_byte;
        end
    end

    // ------------------------------------------------------------------
    // Result build
    // ------------------------------------------------------------------
    function automatic result_t build_result(
        input logic         stick,
        input logic         pres,
        input logic         err_bit,
        input logic         conn,
        input logic         ok,
        input stick_bytes_t b
    );
        result_t r;
        r             = '0;
        r.joy_index   = stick;
        r.present     = pres;
        r.last        = stick;
        r.checksum_ok = ok;
        r.data_error  = pres ? err_bit : conn;
        if (pres)
        begin
            r.axis_x        = {b[SLOT_X_HI], b[SLOT_XY_LO][7:4]};
            r.axis_y        = {b[SLOT_Y_HI], b[SLOT_XY_LO][3:0]};
            r.axis_z        = {b[SLOT_Z_HI], b[SLOT_ZT_LO][7:4]};
            r.axis_throttle = {b[SLOT_T_HI], b[SLOT_ZT_LO][3:0]};
            r.buttons       = b[SLOT_BUTTON][3:0];
            r.hat_raw       = b[SLOT_HAT];
        end
        return r;
    endfunction

    assign res0_next = build_result(1'b0, status_reg[ST_PRESENT0], status_reg[ST_ERROR0],
                                    connected_reg[0], sum_ok, joy_bytes_reg[0]);
    assign res1_next = build_result(1'b1, status_reg[ST_PRESENT1], status_reg[ST_ERROR1],
                                    connected_reg[1], sum_ok, joy_bytes_reg[1]);

    always_ff @(posedge clk)
    begin
        if (in_fire && is_cksum)
        begin
            res0_reg <= res0_next;
            res1_reg <= res1_next;
        end
    end

    // Two-beat output buffer: joystick 0 leaves first, then joystick 1.
    assign out_valid = pend0_reg || pend1_reg;
    assign out_fire  = out_valid && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend0_reg <= 1'b0;
            pend1_reg <= 1'b0;
        end
        else if (in_fire && is_cksum)
        begin
            pend0_reg <= 1'b1;
            pend1_reg <= 1'b1;
        end
        else if (out_fire)
        begin
            if (pend0_reg)
            begin
                pend0_reg <= 1'b0;
            end
            else
            begin
                pend1_reg <= 1'b0;
            end
        end
    end

    assign res_out       = pend0_reg ? res0_reg : res1_reg;
    assign joy_index     = res_out.joy_index;
    assign present       = res_out.present;
    assign axis_x        = res_out.axis_x;
    assign axis_y        = res_out.axis_y;
    assign axis_z        = res_out.axis_z;
    assign axis_throttle = res_out.axis_throttle;
    assign buttons       = res_out.buttons;
    assign hat_raw       = res_out.hat_raw;
    assign data_error    = res_out.data_error;
    assign checksum_ok   = res_out.checksum_ok;
    assign last          = res_out.last;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // The joystick 1 beat is never released ahead of the joystick 0 beat.
    assert property (@(posedge clk) disable iff (!rst_n)
        pend0_reg |-> pend1_reg)
        else $error("joystick 0 result pending without joystick 1 result");

    // The packet position never runs past the checksum byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_STATUS) || (phase_reg == PH_MODE) ||
        (data_off <= data_len))
        else $error("packet position beyond checksum byte");

    // A checksum byte restarts the packet and loads both result beats.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && is_cksum) |=> (phase_reg == PH_STATUS) && pend0_reg && pend1_reg
            && (sum_reg == 8'd0))
        else $error("checksum byte did not restart the packet");

    // Once the joystick 0 beat is taken, the last beat follows at the output.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_fire && pend0_reg) |=> out_valid && last)
        else $error("second result beat missing after the first");

endmodule

// ===== tb/joystick_report_deframer_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// joystick_report_deframer_top_tb: self-checking bench for the report deframer
// Feeds report packets byte by byte: a few hand-picked packets first, then
// random well-formed packets mixed with broken packets and stray bytes. The
// connected mask is changed between runs. Both handshakes are throttled in random
// bursts, bar the last run. Every result beat is checked against a predictor.
// ----------------------------------------------------------------------------
module joystick_report_deframer_top_tb;

    import jrd_pkg::*;

    localparam int CLK_HALF    = 6;
    localparam int CYCLE_LIMIT = 600000;

    localparam logic [PADDR_W-1:0] MASK_ADDR  = {REG_CONNECTED_MASK, 2'b00};
    localparam logic [PADDR_W-1:0] SPARE_ADDR = {~REG_CONNECTED_MASK, 2'b00};

    // Tracks packet framing and holds the report beats still owed by the block.
    class report_tracker;
        logic [1:0] connected;
        logic [4:0] byte_pos;
        logic [7:0] status_byte;
        logic [7:0] byte_sum;
        logic [7:0] stick_data [2*BYTES_PER_STICK];
        result_t    pending_reports [$];
        int         errors;

        function new();
            connected   = '0;
            byte_pos    = PH_STATUS;
            status_byte = '0;
            byte_sum    = '0;
            errors      = 0;
            foreach (stick_data[i]) stick_data[i] = '0;
        endfunction

        function result_t unpack_stick(int stick, bit sum_ok);
            result_t r;
            int      base;
            bit      pres;
            base = stick * BYTES_PER_STICK;
            pres = status_byte[stick == 1 ? ST_PRESENT1 : ST_PRESENT0];
            r = '0;
            r.joy_index = (stick == 1);
            r.present   = pres;
            if (pres)
            begin
                r.axis_x        = {stick_data[base+SLOT_X_HI], stick_data[base+SLOT_XY_LO][7:4]};
                r.axis_y        = {stick_data[base+SLOT_Y_HI], stick_data[base+SLOT_XY_LO][3:0]};
                r.axis_z        = {stick_data[base+SLOT_Z_HI], stick_data[base+SLOT_ZT_LO][7:4]};
                r.axis_throttle = {stick_data[base+SLOT_T_HI], stick_data[base+SLOT_ZT_LO][3:0]};
                r.buttons       = stick_data[base+SLOT_BUTTON][3:0];
                r.hat_raw       = stick_data[base+SLOT_HAT];
                r.data_error    = status_byte[stick == 1 ? ST_ERROR1 : ST_ERROR0];
            end
            else
            begin
                // A stick marked connected that sent nothing is an error.
                r.data_error = connected[stick];
            end
            r.checksum_ok = sum_ok;
            r.last        = (stick == 1);
            return r;
        endfunction

        function void note_byte(logic [7:0] b);
            int ndata;
            int k;
            int stick;
            bit sum_ok;
            ndata = (status_byte[ST_PRESENT0] ? BYTES_PER_STICK : 0) +
                    (status_byte[ST_PRESENT1] ? BYTES_PER_STICK : 0);
            if (byte_pos == PH_STATUS)
            begin
                status_byte = b;
                byte_sum    = b;
                byte_pos    = PH_MODE;
            end
            else if (byte_pos == PH_MODE)
            begin
                byte_sum = byte_sum + b;
                byte_pos = PH_DATA_BASE;
            end
            else if (int'(byte_pos) < int'(PH_DATA_BASE) + ndata)
            begin
                k = int'(byte_pos) - int'(PH_DATA_BASE);
                if (status_byte[ST_PRESENT0])
                    stick = (k < BYTES_PER_STICK) ? 0 : 1;
                else
                    stick = 1;
                stick_data[stick*BYTES_PER_STICK + (k % BYTES_PER_STICK)] = b;
                byte_sum = byte_sum + b;
                byte_pos = byte_pos + 5'd1;
            end
            else
            begin
                sum_ok = (byte_sum == b);
                pending_reports.push_back(unpack_stick(0, sum_ok));
                pending_reports.push_back(unpack_stick(1, sum_ok));
                byte_pos = PH_STATUS;
                byte_sum = '0;
            end
        endfunction

        function void compare_field(string field, logic [11:0] want, logic [11:0] seen);
            if (seen !== want)
            begin
                $display("%0t ERROR: %s expected 0x%0h, got 0x%0h", $time, field, want, seen);
                errors++;
            end
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (pending_reports.size() == 0)
            begin
                $display("%0t ERROR: result beat expected none, got joy_index %0d",
                         $time, got.joy_index);
                errors++;
                return;
            end
            want = pending_reports.pop_front();
            compare_field("joy_index",     12'(want.joy_index),   12'(got.joy_index));
            compare_field("present",       12'(want.present),     12'(got.present));
            compare_field("axis_x",        want.axis_x,           got.axis_x);
            compare_field("axis_y",        want.axis_y,           got.axis_y);
            compare_field("axis_z",        want.axis_z,           got.axis_z);
            compare_field("axis_throttle", want.axis_throttle,    got.axis_throttle);
            compare_field("buttons",       12'(want.buttons),     12'(got.buttons));
            compare_field("hat_raw",       12'(want.hat_raw),     12'(got.hat_raw));
            compare_field("data_error",    12'(want.data_error),  12'(got.data_error));
            compare_field("checksum_ok",   12'(want.checksum_ok), 12'(got.checksum_ok));
            compare_field("last",          12'(want.last),        12'(got.last));
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [31:0]          pwdata;
    logic [31:0]          prdata;
    logic                 pready;
    logic                 in_valid;
    logic                 in_stall;
    logic [7:0]           rx_byte;
    logic                 out_valid;
    logic                 out_stall;
    logic                 joy_index;
    logic                 present;
    logic [AXIS_W-1:0]    axis_x;
    logic [AXIS_W-1:0]    axis_y;
    logic [AXIS_W-1:0]    axis_z;
    logic [AXIS_W-1:0]    axis_throttle;
    logic [3:0]           buttons;
    logic [7:0]           hat_raw;
    logic                 data_error;
    logic                 checksum_ok;
    logic                 last;

    report_tracker tracker;
    bit            idle_en;
    int            bytes_sent;
    int            cycles;

    joystick_report_deframer_top u_top (.*);

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Result monitor: a beat moves when out_valid is high and out_stall low.
    always @(posedge clk)
    begin : result_monitor
        result_t got;
        if (rst_n && out_valid && !out_stall)
        begin
            got.joy_index     = joy_index;
            got.present       = present;
            got.axis_x        = axis_x;
            got.axis_y        = axis_y;
            got.axis_z        = axis_z;
            got.axis_throttle = axis_throttle;
            got.buttons       = buttons;
            got.hat_raw       = hat_raw;
            got.data_error    = data_error;
            got.checksum_ok   = checksum_ok;
            got.last          = last;
            tracker.check_result(got);
        end
    end

    // Output back-pressure in random bursts.
    initial
    begin : stall_gen
        int hold;
        hold = 0;
        forever
        begin
            @(negedge clk);
            if (hold > 0)
                hold--;
            else if (idle_en && $urandom_range(0, 7) == 0)
            begin
                hold = $urandom_range(1, 19) - 1;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [31:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_connected(input logic [1:0] mask);
        logic [31:0] data;
        // Upper bits carry junk, and a write to the unused slot must not land.
        data = $urandom;
        data[1:0] = mask;
        apb_write(MASK_ADDR, data);
        tracker.connected = mask;
        apb_write(SPARE_ADDR, $urandom);
    endtask

    task automatic send_byte(input logic [7:0] b);
        int gap;
        @(negedge clk);
        if (idle_en && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 19);
            in_valid <= 1'b0;
            rx_byte  <= 8'($urandom);
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        do @(posedge clk); while (in_stall);
        tracker.note_byte(b);
        bytes_sent++;
    endtask

    function automatic logic [7:0] random_data();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(0, 1) ? 8'hFF : 8'h00;
        return 8'($urandom);
    endfunction

    task automatic send_packet(input logic [7:0] status, input logic [7:0] mode,
                               input bit rand_data, input logic [7:0] fill,
                               input bit bad_sum);
        logic [7:0] sum;
        logic [7:0] d;
        int         ndata;
        ndata = (status[ST_PRESENT0] ? BYTES_PER_STICK : 0) +
                (status[ST_PRESENT1] ? BYTES_PER_STICK : 0);
        sum = status + mode;
        send_byte(status);
        send_byte(mode);
        for (int i = 0; i < ndata; i++)
        begin
            d = rand_data ? random_data() : fill;
            sum = sum + d;
            send_byte(d);
        end
        if (bad_sum)
            sum = sum + 8'($urandom_range(1, 255));
        send_byte(sum);
    endtask

    // Completes whatever packet the stream is in, so the next byte is status.
    task automatic finish_packet();
        while (tracker.byte_pos != PH_STATUS)
            send_byte(8'($urandom));
    endtask

    // The last byte stays on the bus after it is taken, so drop valid first.
    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (tracker.pending_reports.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic run_random(input int nbytes);
        int stop_at;
        int pick;
        stop_at = bytes_sent + nbytes;
        while (bytes_sent < stop_at)
        begin
            pick = $urandom_range(0, 19);
            if (pick < 16)
                send_packet(8'($urandom), 8'($urandom), 1'b1, 8'h00,
                            $urandom_range(0, 4) == 0);
            else if (pick < 18)
            begin
                repeat ($urandom_range(1, 20)) send_byte(8'($urandom));
                finish_packet();
            end
            else
                send_packet(8'($urandom), 8'($urandom), 1'b1, 8'h00, 1'b1);
            if ($urandom_range(0, 29) == 0)
                wait_drained();
        end
    endtask

    initial
    begin
        tracker    = new();
        idle_en    = 1'b1;
        bytes_sent = 0;
        rst_n      = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        in_valid   = 1'b0;
        rx_byte    = '0;
        out_stall  = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        set_connected(2'b11);
        // Error bits with no data, a bad checksum, then every bit set.
        send_packet(8'h30, 8'h00, 1'b0, 8'h00, 1'b0);
        send_packet(8'h00, 8'hFF, 1'b0, 8'h00, 1'b1);
        send_packet(8'hFF, 8'hFF, 1'b0, 8'hFF, 1'b0);
        wait_drained();

        set_connected(2'b00);
        run_random(250);
        wait_drained();
        set_connected(2'b01);
        run_random(250);
        wait_drained();
        set_connected(2'b10);
        run_random(250);
        wait_drained();

        // Last stretch runs at full rate on both sides.
        idle_en = 1'b0;
        set_connected(2'b11);
        run_random(250);

        @(negedge clk);
        in_valid <= 1'b0;
        while (tracker.pending_reports.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (tracker.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/jrd_pkg.sv
rtl/joystick_report_deframer_top.sv
tb/joystick_report_deframer_top_tb.sv
